@@ hw/rtl/rtse_pkg.sv @@
// ----------------------------------------------------------------------------
// rtse_pkg
// shared widths, constants and status codes of the rx timestamp seconds
// extension block
// ----------------------------------------------------------------------------
package rtse_pkg;

  localparam int unsigned FracW    = 27;
  localparam int unsigned SecW     = 32;
  localparam int unsigned NsW      = 30;
  localparam int unsigned FlagW    = 2;
  localparam int unsigned WordW    = 32;
  localparam int unsigned StatusW  = 2;

  // input tdata: tick_seconds, tick_fraction, tick_flags, prefix_word, pad
  localparam int unsigned InDataW  = 96;
  // output tdata: seconds, nanoseconds, clock_flags
  localparam int unsigned OutDataW = 64;

  localparam int unsigned ProdW    = FracW + NsW;

  localparam logic [NsW-1:0]   NsPerSec     = 30'd1000000000;
  localparam logic [FracW:0]   OneSecond    = 28'h8000000;
  localparam int unsigned      TicksPerSec  = 4;
  localparam logic [FracW-1:0] SyncDelayMax = 27'h1999999;
  localparam logic [FracW-1:0] PktDelayMax  = 27'h0CCCCCC;
  // window limits on the modular distance from the tick fraction
  localparam logic [FracW-1:0] AfterLimit   =
      FracW'(OneSecond / TicksPerSec) + SyncDelayMax;
  localparam logic [FracW-1:0] BeforeLimit  = FracW'(OneSecond - {1'b0, PktDelayMax});
  localparam logic [SecW-1:0]  NeverSecs    = '1;
  localparam int unsigned      NoTsBit      = 31;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_NO_TS      = 2'd1,
    ST_NEVER      = 2'd2,
    ST_NOT_SYNCED = 2'd3
  } status_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    REG_FRACTION_CORRECTION = 1'b0
  } reg_idx_e;

endpackage

@@ hw/rtl/rx_timestamp_seconds_extension.sv @@
// ----------------------------------------------------------------------------
// rx_timestamp_seconds_extension
// extends 27-bit receive timestamp fractions to full seconds and nanoseconds
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects the operation. A sync tick (tuser 0)
// stores seconds, fraction and clock flags and marks the block synced. A
// packet query (tuser 1) carries the packet prefix word; its fraction plus
// fraction_correction is scaled to nanoseconds and placed in the second
// nearest the last sync tick.
// Output stream (m_axis): exactly one result per input transaction, in
// order; tuser holds the status, tdata seconds, nanoseconds and flags.
// From input acceptance a transaction passes one input register, then a single
// pass of correction add, distance compare and a 27x30 constant multiply into
// the result register. Throughput is one transaction per cycle while m_axis
// does not stall; the result register stage sets that figure. When m_axis
// stalls the result register holds and the input register, if empty, still
// takes one more transaction before s_axis_tready drops. Reset clears both
// stages and fraction_correction and marks the block never synced (seconds
// all ones). APB writes fraction_correction at address 0; the user must write
// it only while no transaction is in flight; the block does not enforce it.
module rx_timestamp_seconds_extension (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [31:0] tick_seconds, [58:32] tick_fraction, [60:59] tick_flags,
  // [92:61] prefix_word, [95:93] zero
  input  logic [rtse_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] operation
  input  logic                           s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] seconds, [61:32] nanoseconds, [63:62] clock_flags
  output logic [rtse_pkg::OutDataW-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [rtse_pkg::StatusW-1:0]   m_axis_tuser,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import rtse_pkg::*;

  // configuration register
  logic [FracW-1:0] corr_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (reg_idx_e'(paddr[2]) == REG_FRACTION_CORRECTION);
  assign prdata = (reg_idx_e'(paddr[2]) == REG_FRACTION_CORRECTION) ?
                  {{(32-FracW){1'b0}}, corr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= '0;
    end else if (cfg_wr) begin
      corr_q <= pwdata[FracW-1:0];
    end
  end

  // pipeline control
  logic in_valid_q, out_valid_q;
  logic advance, in_take;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  // input register
  op_e              op_q;
  logic [SecW-1:0]  tick_sec_q;
  logic [FracW-1:0] tick_frac_q;
  logic [FlagW-1:0] tick_flags_q;
  logic [WordW-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q         <= op_e'(s_axis_tuser);
      tick_sec_q   <= s_axis_tdata[31:0];
      tick_frac_q  <= s_axis_tdata[58:32];
      tick_flags_q <= s_axis_tdata[60:59];
      word_q       <= s_axis_tdata[92:61];
    end
  end

  // sync state
  logic [SecW-1:0]  sync_sec_q, sync_sec_d;
  logic [FracW-1:0] sync_frac_q, sync_frac_d;
  logic [FlagW-1:0] held_flags_q, held_flags_d;
  logic             synced_q, synced_d;

  // single pass
  logic [FracW-1:0] frac, distance;
  logic [FracW:0]   sum;
  logic [ProdW-1:0] prod;
  logic             no_ts, in_after, in_before;
  status_e          status_d;
  logic [SecW-1:0]  sec_d;
  logic [NsW-1:0]   ns_d;
  logic [FlagW-1:0] flags_d;
  logic             fire;

  assign fire = in_valid_q && advance;

  always_comb begin
    frac      = word_q[FracW-1:0] + corr_q;
    no_ts     = word_q[NoTsBit];
    distance  = frac - sync_frac_q;
    sum       = {1'b0, distance} + {1'b0, sync_frac_q};
    prod      = ProdW'(frac) * ProdW'(NsPerSec);
    in_after  = distance < AfterLimit;
    in_before = distance > BeforeLimit;

    sync_sec_d   = sync_sec_q;
    sync_frac_d  = sync_frac_q;
    held_flags_d = held_flags_q;
    synced_d     = synced_q;
    status_d     = ST_OK;
    sec_d        = '0;
    ns_d         = '0;
    flags_d      = '0;

    if (op_q == OP_TICK) begin
      sync_sec_d   = tick_sec_q;
      sync_frac_d  = tick_frac_q;
      held_flags_d = tick_flags_q;
      synced_d     = 1'b1;
    end else if (no_ts) begin
      status_d = ST_NO_TS;
    end else if (synced_q && (in_after || in_before)) begin
      ns_d    = prod[ProdW-1:FracW];
      flags_d = held_flags_q;
      // carry if after, none if before: a new second between tick and packet
      if (in_after) begin
        sec_d = sync_sec_q + SecW'(sum[FracW]);
      end else begin
        sec_d = sync_sec_q - SecW'(!sum[FracW]);
      end
    end else begin
      synced_d = 1'b0;
      status_d = (sync_sec_q == NeverSecs) ? ST_NEVER : ST_NOT_SYNCED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      sync_sec_q   <= NeverSecs;
      sync_frac_q  <= '0;
      held_flags_q <= '0;
      synced_q     <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        sync_sec_q   <= sync_sec_d;
        sync_frac_q  <= sync_frac_d;
        held_flags_q <= held_flags_d;
        synced_q     <= synced_d;
      end
    end
  end

  // result register
  status_e          res_status_q;
  logic [SecW-1:0]  res_sec_q;
  logic [NsW-1:0]   res_ns_q;
  logic [FlagW-1:0] res_flags_q;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_status_q <= status_d;
      res_sec_q    <= sec_d;
      res_ns_q     <= ns_d;
      res_flags_q  <= flags_d;
    end
  end

  assign m_axis_tuser = res_status_q;
  assign m_axis_tdata = {res_flags_q, res_ns_q, res_sec_q};

  // checks
  a_tick_syncs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_q == OP_TICK) |=> synced_q)
    else $error("sync tick did not mark the block synced");

  a_bad_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_status_q != ST_OK) |-> (m_axis_tdata == '0))
    else $error("non-ok result carries data");

  a_ns_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_ns_q < NsPerSec))
    else $error("nanoseconds out of range");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  a_lost_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_q == OP_QUERY) && (status_d == ST_NOT_SYNCED || status_d == ST_NEVER)
    |=> !synced_q)
    else $error("sync kept after a failed query");

endmodule
